>>> rtl/rrlm_pkg.sv
// shared types and constants for the request/response latency matcher
`timescale 1ns / 1ps

package rrlm_pkg;

	// microseconds in one second, used to scale a seconds difference
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// field widths
	localparam int PORT_W = 16;
	localparam int TAG_W  = 32;
	localparam int SEC_W  = 32;
	localparam int USEC_W = 20;
	localparam int TIME_W = SEC_W + USEC_W;
	localparam int OUT_W  = 64;

	// value of a tag slot after reset
	localparam logic [TAG_W-1:0] TAG_RESET = '1;

	// event kinds
	localparam logic KIND_REQUEST  = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;

	// sequencer states
	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_QUO   = 7'b0000100,
		ST_ADDR  = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_EVAL  = 7'b0100000,
		ST_SUM   = 7'b1000000
	} state_t;

endpackage

>>> rtl/request_response_latency_matcher_core.sv
// top level of the request/response latency matcher: slot table and delay arithmetic
`timescale 1ns / 1ps

// Matches response items to request items by client port and sequence tag and reports
// the delay in microseconds, plus the request time relative to a start time captured on
// the first match. The per-port table sits in two single-port synchronous memories
// (tag, and seconds/microseconds), indexed by client_port modulo PORT_SLOTS. After
// reset the block runs a clearing pass over all PORT_SLOTS entries, writing one
// entry a cycle, and accepts no item until it ends. After that, one item is handled at
// a time by a sequencer that steps through the slot reduction (reciprocal multiply, then
// multiply and subtract), the registered table read, the evaluate-and-write-back step
// and, for a matching response, the 64-bit sum after the registered 32x20 products,
// before it takes the next item. A finished result waits in an output register, so the
// next item is taken while it stays unclaimed; only a second result stalls.
module request_response_latency_matcher_core
	import rrlm_pkg::*;
#(
	parameter int PORT_SLOTS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [PORT_W-1:0] client_port,
	input  logic [TAG_W-1:0]  seq_tag,
	input  logic [SEC_W-1:0]  ts_sec,
	input  logic [USEC_W-1:0] ts_usec,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  delay_us,
	output logic [OUT_W-1:0]  request_time_us
);

	// table geometry and the reciprocal for the slot reduction
	localparam int AW   = $clog2(PORT_SLOTS);
	localparam int QMAX = 65535 / PORT_SLOTS;
	localparam int QW   = $clog2(QMAX + 2);
	localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(PORT_SLOTS) - 64'd1)
		/ 64'(PORT_SLOTS));
	localparam logic [PORT_W-1:0] SLOTS_W = PORT_W'(PORT_SLOTS - 1) + PORT_W'(1);

	state_t state_q;

	// captured item
	logic              kind_q;
	logic [PORT_W-1:0] port_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SEC_W-1:0]  sec_q;
	logic [USEC_W-1:0] usec_q;

	// slot reduction
	logic [QW-1:0]     quo_q;
	logic [AW-1:0]     slot_q;
	logic [48:0]       quo_prod;
	logic [PORT_W-1:0] quo_times_n;
	logic [PORT_W-1:0] slot_full;

	// clearing pass
	logic [AW-1:0] clr_addr_q;

	// table memories and read data
	logic [TAG_W-1:0]  tag_mem  [PORT_SLOTS];
	logic [TIME_W-1:0] time_mem [PORT_SLOTS];
	logic [TAG_W-1:0]  rd_tag_q;
	logic [TIME_W-1:0] rd_time_q;

	// write port
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [TAG_W-1:0]  mem_tag_wd;
	logic [TIME_W-1:0] mem_time_wd;

	// start time
	logic [SEC_W-1:0]  start_sec_q;
	logic [USEC_W-1:0] start_usec_q;
	logic              start_zero;

	// evaluate stage
	logic              hit;
	logic [SEC_W-1:0]  rd_sec;
	logic [USEC_W-1:0] rd_usec;
	logic [SEC_W-1:0]  dsec;
	logic [SEC_W-1:0]  rsec;

	// registered products and operands for the sum
	logic [51:0]       dprod_q;
	logic [51:0]       rprod_q;
	logic [USEC_W-1:0] ru_q;
	logic              first_q;

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] delay_q;
	logic [OUT_W-1:0] rel_q;
	logic             out_free;

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign delay_us        = delay_q;
	assign request_time_us = rel_q;
	assign out_free        = !out_valid_q || out_ready;

	// quotient of the port by the slot count, exact for 16-bit ports
	assign quo_prod    = 49'(port_q) * 49'(RECIP);
	assign quo_times_n = PORT_W'(PORT_W'(quo_q) * SLOTS_W);
	assign slot_full   = port_q - quo_times_n;

	// stored entry fields and match test
	assign rd_sec     = rd_time_q[TIME_W-1 -: SEC_W];
	assign rd_usec    = rd_time_q[USEC_W-1:0];
	assign hit        = (rd_tag_q == tag_q);
	assign start_zero = (start_sec_q == '0) && (start_usec_q == '0);
	assign dsec       = sec_q - rd_sec;
	assign rsec       = rd_sec - start_sec_q;

	// single write port shared by the clearing pass and request updates
	always_comb begin
		mem_we      = 1'b0;
		mem_addr    = slot_q;
		mem_tag_wd  = tag_q;
		mem_time_wd = {sec_q, usec_q};
		if (state_q == ST_CLEAR) begin
			mem_we      = 1'b1;
			mem_addr    = clr_addr_q;
			mem_tag_wd  = TAG_RESET;
			mem_time_wd = '0;
		end else if (state_q == ST_EVAL && kind_q == KIND_REQUEST && !hit) begin
			mem_we = 1'b1;
		end
	end

	// table memories, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_addr]  <= mem_tag_wd;
			time_mem[mem_addr] <= mem_time_wd;
		end
		if (state_q == ST_READ) begin
			rd_tag_q  <= tag_mem[slot_q];
			rd_time_q <= time_mem[slot_q];
		end
	end

	// item capture, slot reduction and products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			port_q <= client_port;
			tag_q  <= seq_tag;
			sec_q  <= ts_sec;
			usec_q <= ts_usec;
		end
		if (state_q == ST_QUO) begin
			quo_q <= quo_prod[32 +: QW];
		end
		if (state_q == ST_ADDR) begin
			slot_q <= slot_full[AW-1:0];
		end
		if (state_q == ST_EVAL) begin
			dprod_q <= 52'(dsec) * 52'(USEC_PER_SEC);
			rprod_q <= 52'(rsec) * 52'(USEC_PER_SEC);
			ru_q    <= rd_usec;
			first_q <= start_zero;
		end
	end

	// sequencer, clearing pass, start time and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			start_sec_q  <= '0;
			start_usec_q <= '0;
			out_valid_q  <= 1'b0;
			delay_q      <= '0;
			rel_q        <= '0;
		end else begin
			// the sum stage refills the output register itself
			if (out_valid_q && out_ready && state_q != ST_SUM) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(PORT_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_QUO;
					end
				end
				ST_QUO: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (kind_q == KIND_RESPONSE && hit) begin
						// capture the start on the first match while it is still zero
						if (start_zero) begin
							start_sec_q  <= rd_sec;
							start_usec_q <= rd_usec;
						end
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						delay_q     <= 64'(dprod_q) + 64'(usec_q) - 64'(ru_q);
						rel_q       <= first_q ? '0
							: 64'(rprod_q) + 64'(ru_q) - 64'(start_usec_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
